[rtl/rws_pkg.sv]
// Shared widths and constants for the roulette-wheel edge select block.
// No dependencies; imported by every module of the block.
`default_nettype none
package rws_pkg;

  localparam int PHER_W        = 32;  // pheromone level, unsigned Q16.16
  localparam int LEN_W         = 16;  // edge length
  localparam int FRAC_W        = 16;  // random fraction, value/65536
  localparam int NODE_W        = 6;   // chosen node index on the output
  localparam int WEIGHT_W      = 32;  // stored weight, unsigned Q16.16
  localparam int MAX_NODES_DEF = 64;  // default row capacity

  // Divider: quotient bits retired per cycle and steps per division.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = PHER_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [NODE_W-1:0] DEFAULT_NODE = NODE_W'(1);

endpackage
`default_nettype wire

[rtl/rws_div.sv]
// Iterative restoring divider, 32-bit dividend by 16-bit divisor.
// Retires DIV_BITS quotient bits per cycle; depends on rws_pkg.
`default_nettype none
module rws_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rws_pkg::PHER_W-1:0] dividend,
  input  wire logic [rws_pkg::LEN_W-1:0]  divisor,
  output logic                            done,
  output logic [rws_pkg::PHER_W-1:0]      quotient
);
  import rws_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PHER_W-1:0]    quo;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     dvs;
  logic [PHER_W-1:0]    quo_next;
  logic [LEN_W-1:0]     rem_next;

  // Shift in one dividend bit per step, subtract when the divisor fits.
  always_comb begin
    logic [LEN_W:0]    r;
    logic [PHER_W-1:0] q;
    r = {1'b0, rem};
    q = quo;
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {r[LEN_W-1:0], q[PHER_W-1]};
      q = {q[PHER_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    rem_next = r[LEN_W-1:0];
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

[rtl/rws_wmem.sv]
// Weight store: one write port, one read port, registered read data.
// Depends on rws_pkg for the weight width.
`default_nettype none
module rws_wmem #(
  parameter int DEPTH = rws_pkg::MAX_NODES_DEF,
  parameter int AW    = $clog2(rws_pkg::MAX_NODES_DEF)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [rws_pkg::WEIGHT_W-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [rws_pkg::WEIGHT_W-1:0] rdata
);
  import rws_pkg::*;

  logic [WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/roulette_wheel_edge_select_core.sv]
// Roulette-wheel edge select core: top level. Instantiates rws_div (weight
// divider) and rws_wmem (weight store); depends on rws_pkg.
//
// One candidate node arrives per input word, numbered 0, 1, 2, ... within a
// row. Each node gets the weight pheromone_level / edge_length (truncated,
// Q16.16), or zero when the node is visited or has no edge; weights go to an
// on-chip store and into a running total. The word with is_last set closes
// the row: the threshold total * random_fraction is formed, the store is
// scanned in node order with a running prefix sum, and the first node whose
// prefix * 65536 exceeds the threshold is returned. When none does, node 1
// is returned with used_default set. Words beyond MAX_NODES in a row are
// dropped and reported through overflow on the row's result. A node that
// needs a division holds the block through the accept, the steps of the
// 4-bit-per-cycle divider and the store write; a zero-weight or dropped
// node is handled on acceptance, with no divider pass. A last word then goes
// through the threshold multiply, the scan (one store read per cycle over
// the N stored nodes, registered read data, stopping at the first hit or at
// the end of the row) and the hand-over to the output register. The output
// register holds a result until taken while the next row's words are already being accepted.
`default_nettype none
module roulette_wheel_edge_select_core #(
  parameter int MAX_NODES = rws_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rws_pkg::PHER_W-1:0] pheromone_level,
  input  wire logic [rws_pkg::LEN_W-1:0]  edge_length,
  input  wire logic                       visited,
  input  wire logic [rws_pkg::FRAC_W-1:0] random_fraction,
  input  wire logic                       is_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rws_pkg::NODE_W-1:0]      chosen_node,
  output logic                            used_default,
  output logic                            overflow
);
  import rws_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);       // store address
  localparam int CNT_W = $clog2(MAX_NODES + 1);   // fill count, holds MAX_NODES
  localparam int TOT_W = WEIGHT_W + IDX_W;        // running total / prefix
  localparam int THR_W = TOT_W + FRAC_W;          // scaled threshold

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  // Row state
  logic [CNT_W-1:0]  count;
  logic [TOT_W-1:0]  total;
  logic              ovf_seen;
  logic              last_q;
  logic [FRAC_W-1:0] frac_q;

  // Scan state
  logic [THR_W-1:0]  thresh;
  logic [CNT_W-1:0]  raddr;
  logic [CNT_W-1:0]  ridx;
  logic              rd_pend;
  logic [TOT_W-1:0]  prefix;
  logic [NODE_W-1:0] res_node;
  logic              res_dflt;

  // Store and divider hookup
  logic                mem_we;
  logic [WEIGHT_W-1:0] mem_wdata;
  logic                mem_re;
  logic [WEIGHT_W-1:0] mem_rdata;
  logic                div_start;
  logic                div_done;
  logic [PHER_W-1:0]   div_quo;

  logic              in_acc;
  logic              room;
  logic              zero_w;
  logic [TOT_W-1:0]  prefix_sum;
  logic              hit;
  logic              scan_end;
  logic              out_load;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign room     = (count < CNT_W'(MAX_NODES));
  assign zero_w   = (edge_length == '0) || visited;

  // Start the divider only for a stored node with a real weight.
  assign div_start = in_acc && room && !zero_w;

  // Write a zero weight at once; a divided weight when the divider is done.
  assign mem_we    = (in_acc && room && zero_w) || (state == S_DIV && div_done);
  assign mem_wdata = (state == S_DIV) ? WEIGHT_W'(div_quo) : '0;

  // Issue one read per scan cycle while stored nodes remain.
  assign mem_re = (state == S_SCAN) && (raddr != count);

  // Compare prefix * 65536 against total * fraction, both exact.
  assign prefix_sum = prefix + TOT_W'(mem_rdata);
  assign hit        = rd_pend && ({prefix_sum, {FRAC_W{1'b0}}} > thresh);
  assign scan_end   = !rd_pend && (raddr == count);

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  rws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pheromone_level),
    .divisor  (edge_length),
    .done     (div_done),
    .quotient (div_quo)
  );

  rws_wmem #(
    .DEPTH (MAX_NODES),
    .AW    (IDX_W)
  ) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (raddr[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  // Control: sequencer, row bookkeeping and the output register's valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      ovf_seen  <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the output word once taken; a new load overrides.
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!room) begin
              ovf_seen <= 1'b1;
              if (is_last) state <= S_MUL;
            end else if (zero_w) begin
              count <= count + CNT_W'(1);
              if (is_last) state <= S_MUL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= count + CNT_W'(1);
            total <= total + TOT_W'(div_quo);
            state <= last_q ? S_MUL : S_IDLE;
          end
        end
        S_MUL: begin
          rd_pend <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (hit || scan_end) begin
            rd_pend <= 1'b0;
            state   <= S_OUT;
          end else begin
            rd_pend <= mem_re;
          end
        end
        S_OUT: begin
          // Hand the result over, then start the next row afresh.
          if (out_load) begin
            count    <= '0;
            total    <= '0;
            ovf_seen <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_q <= is_last;
      frac_q <= random_fraction;
    end

    if (state == S_MUL) begin
      thresh <= THR_W'(total * frac_q);
      raddr  <= '0;
      ridx   <= '0;
      prefix <= '0;
    end else if (state == S_SCAN) begin
      if (mem_re) raddr <= raddr + CNT_W'(1);
      if (rd_pend) begin
        prefix <= prefix_sum;
        ridx   <= ridx + CNT_W'(1);
      end
      if (hit) begin
        res_node <= NODE_W'(ridx);
        res_dflt <= 1'b0;
      end else if (scan_end) begin
        res_node <= DEFAULT_NODE;
        res_dflt <= 1'b1;
      end
    end

    if (out_load) begin
      chosen_node  <= res_node;
      used_default <= res_dflt;
      overflow     <= ovf_seen;
    end
  end

  // The fill count never passes the store's depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NODES))
    else $error("fill count beyond capacity");

  // Store writes happen only while loading a row, never during the scan.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_DIV))
    else $error("weight store written outside the load phase");

  // Returning read data always belongs to a stored node of this row.
  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rd_pend) |-> (ridx < count))
    else $error("scan read beyond the stored nodes");

  // Handing a result over clears the row.
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (count == '0 && total == '0 && !ovf_seen))
    else $error("row state not cleared after result");

endmodule
`default_nettype wire

[sim/rws_selection_checker.sv]
// Selection checker for the roulette-wheel edge select core: watches both
// channels, predicts each row's selection and compares it with the result.
// Depends on rws_pkg for field widths and the default node.
module rws_selection_checker #(
  parameter int MAX_NODES = rws_pkg::MAX_NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [rws_pkg::PHER_W-1:0] pheromone_level,
  input  logic [rws_pkg::LEN_W-1:0]  edge_length,
  input  logic                       visited,
  input  logic [rws_pkg::FRAC_W-1:0] random_fraction,
  input  logic                       is_last,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [rws_pkg::NODE_W-1:0] chosen_node,
  input  logic                       used_default,
  input  logic                       overflow,
  output int                         errors,
  output int                         pending,
  output int                         selections_seen,
  output int                         defaults_seen,
  output int                         overflows_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rws_pkg::*;

  localparam int TOTAL_W = WEIGHT_W + $clog2(MAX_NODES);

  typedef struct packed {
    logic [NODE_W-1:0] chosen;
    logic              fallback;
    logic              dropped;
  } selection_t;

  logic [WEIGHT_W-1:0] row_weight [MAX_NODES];
  logic [TOTAL_W-1:0]  row_total;
  int unsigned         row_fill;
  logic                row_dropped;
  selection_t          selection_q [$];

  // Fold one candidate into the row; on the last word, spin the wheel.
  task automatic absorb_candidate(input logic [PHER_W-1:0] pher,
                                  input logic [LEN_W-1:0]  len,
                                  input logic              vis,
                                  input logic [FRAC_W-1:0] frac,
                                  input logic              last);
    logic [WEIGHT_W-1:0] w;
    logic [63:0]         scaled_threshold;
    logic [63:0]         prefix;
    selection_t          pick;
    int unsigned         i;
    if (row_fill < MAX_NODES) begin
      w = (len != '0 && !vis) ? pher / len : '0;
      row_weight[row_fill] = w;
      row_total += TOTAL_W'(w);
      row_fill++;
    end else begin
      row_dropped = 1'b1;
    end
    if (last) begin
      scaled_threshold = 64'(row_total) * 64'(frac);
      prefix = '0;
      pick.chosen = DEFAULT_NODE;
      pick.fallback = 1'b1;
      pick.dropped = row_dropped;
      for (i = 0; i < row_fill && pick.fallback; i++) begin
        prefix += 64'(row_weight[i]);
        if ((prefix << 16) > scaled_threshold) begin
          pick.chosen = NODE_W'(i);
          pick.fallback = 1'b0;
        end
      end
      selection_q.push_back(pick);
      row_total = '0;
      row_fill = 0;
      row_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    selection_t exp_sel;
    if (rst) begin
      selection_q.delete();
      row_total = '0;
      row_fill = 0;
      row_dropped = 1'b0;
    end else begin
      // Check the departing result first: it always belongs to an older row.
      if (out_valid && out_ready) begin
        selections_seen++;
        if (used_default === 1'b1) defaults_seen++;
        if (overflow === 1'b1) overflows_seen++;
        if (selection_q.size() == 0) begin
          errors++;
          $error("result with no selection pending: node %0d default %0b overflow %0b",
                 chosen_node, used_default, overflow);
        end else begin
          exp_sel = selection_q.pop_front();
          if (chosen_node !== exp_sel.chosen) begin
            errors++;
            $error("chosen_node: expected %0d, got %0d", exp_sel.chosen, chosen_node);
          end
          if (used_default !== exp_sel.fallback) begin
            errors++;
            $error("used_default: expected %0b, got %0b", exp_sel.fallback, used_default);
          end
          if (overflow !== exp_sel.dropped) begin
            errors++;
            $error("overflow: expected %0b, got %0b", exp_sel.dropped, overflow);
          end
        end
      end
      if (in_valid && in_ready)
        absorb_candidate(pheromone_level, edge_length, visited, random_fraction, is_last);
    end
    pending = selection_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    selections_seen = 0;
    defaults_seen = 0;
    overflows_seen = 0;
  end

endmodule

[sim/roulette_wheel_edge_select_core_tb.sv]
// Testbench top for roulette_wheel_edge_select_core: drives rows of candidate
// words and gives the verdict. Depends on rws_pkg, the core and
// rws_selection_checker, which predicts and compares every selection.
module roulette_wheel_edge_select_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rws_pkg::*;

  // Longest run of cycles with no word moving on either channel. A full row
  // of 64 weighted nodes plus its scan stays far below this even when the
  // receiver stalls most of the time.
  localparam int STALL_LIMIT = 3000;
  localparam int WORDS_PER_PHASE = 550;
  localparam int DRAIN_CYCLES = 2 * MAX_NODES_DEF + 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PHER_W-1:0] pheromone_level = '0;
  logic [LEN_W-1:0]  edge_length = '0;
  logic              visited = 1'b0;
  logic [FRAC_W-1:0] random_fraction = '0;
  logic              is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [NODE_W-1:0] chosen_node;
  logic              used_default;
  logic              overflow;

  int errors, pending, selections_seen, defaults_seen, overflows_seen;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int words_sent = 0;
  int rows_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  roulette_wheel_edge_select_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pheromone_level (pheromone_level),
    .edge_length     (edge_length),
    .visited         (visited),
    .random_fraction (random_fraction),
    .is_last         (is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .chosen_node     (chosen_node),
    .used_default    (used_default),
    .overflow        (overflow)
  );

  rws_selection_checker u_selection_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pheromone_level (pheromone_level),
    .edge_length     (edge_length),
    .visited         (visited),
    .random_fraction (random_fraction),
    .is_last         (is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .chosen_node     (chosen_node),
    .used_default    (used_default),
    .overflow        (overflow),
    .errors          (errors),
    .pending         (pending),
    .selections_seen (selections_seen),
    .defaults_seen   (defaults_seen),
    .overflows_seen  (overflows_seen)
  );

  // Receiver: stall at the current idle rate, decided fresh every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one candidate word and hold it until the core takes it. Idle
  // cycles in front of it carry junk payload with valid low.
  task automatic push_candidate(input logic [PHER_W-1:0] pher,
                                input logic [LEN_W-1:0]  len,
                                input logic              vis,
                                input logic [FRAC_W-1:0] frac,
                                input logic              last);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      pheromone_level <= $urandom;
      edge_length <= LEN_W'($urandom);
      visited <= 1'($urandom);
      random_fraction <= FRAC_W'($urandom);
      is_last <= 1'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pheromone_level <= pher;
    edge_length <= len;
    visited <= vis;
    random_fraction <= frac;
    is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (last) rows_sent++;
  endtask

  // Send one row of n candidates with random content; the last word closes it.
  task automatic random_row(input int n);
    logic [PHER_W-1:0] pher;
    logic [LEN_W-1:0]  len;
    logic [FRAC_W-1:0] frac;
    logic              vis;
    int                k;
    int                pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      case (pick) inside
        0:       pher = '0;
        1:       pher = '1;
        [2:3]:   pher = $urandom_range(0, 255);
        default: pher = $urandom;
      endcase
      pick = $urandom_range(9);
      if (pick == 0) len = '0;
      else if (pick < 6) len = LEN_W'($urandom_range(1, 16));
      else len = LEN_W'($urandom);
      pick = $urandom_range(19);
      if (pick == 0) frac = '0;
      else if (pick == 1) frac = '1;
      else frac = FRAC_W'($urandom);
      vis = ($urandom_range(99) < 20);
      push_candidate(pher, len, vis, frac, k == n - 1);
    end
  endtask

  // Row lengths: mostly short, some medium, a few at or past capacity.
  task automatic random_phase(input int word_budget);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < word_budget) begin
      pick = $urandom_range(99);
      if (pick < 60) random_row($urandom_range(1, 6));
      else if (pick < 85) random_row($urandom_range(7, 20));
      else if (pick < 95) random_row($urandom_range(21, 63));
      else random_row($urandom_range(MAX_NODES_DEF, MAX_NODES_DEF + 6));
    end
  endtask

  // Lower valid and hold off until every selection has come back.
  task automatic drain_selections();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: lone nodes, zero weights, extreme fields.
    tx_idle_pct = 11;
    rx_idle_pct = 85;
    push_candidate(32'h0001_0000, 16'd3, 1'b0, 16'h0000, 1'b1);  // lone weighted node
    push_candidate(32'hFFFF_FFFF, 16'd1, 1'b1, 16'h8000, 1'b1);  // lone visited node
    push_candidate(32'hFFFF_FFFF, 16'd0, 1'b0, 16'hFFFF, 1'b1);  // lone node, no edge
    push_candidate(32'hFFFF_FFFF, 16'd1, 1'b0, 16'h1234, 1'b0);  // largest weight
    push_candidate(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1);
    push_candidate(32'h0000_0000, 16'd5, 1'b0, 16'hFFFF, 1'b0);  // every weight zero
    push_candidate(32'hFFFF_FFFF, 16'd0, 1'b0, 16'h0000, 1'b0);
    push_candidate(32'h8000_0000, 16'd2, 1'b1, 16'h0001, 1'b1);
    push_candidate(32'h0000_0000, 16'd1, 1'b0, 16'h0000, 1'b0);  // zero ahead of the pick
    push_candidate(32'h0000_0001, 16'hFFFF, 1'b0, 16'h0000, 1'b0);
    push_candidate(32'h0000_0001, 16'd1, 1'b0, 16'h0000, 1'b0);
    push_candidate(32'h0000_0001, 16'd1, 1'b0, 16'hFFFF, 1'b1);  // top of the wheel
    push_candidate(32'h0000_FFFF, 16'h8000, 1'b0, 16'h5555, 1'b0);
    push_candidate(32'hAAAA_AAAA, 16'h5555, 1'b0, 16'hAAAA, 1'b0);
    push_candidate(32'h5555_5555, 16'hAAAA, 1'b1, 16'h7FFF, 1'b0);
    push_candidate(32'h0001_0000, 16'd1, 1'b0, 16'h8000, 1'b1);

    // Capacity edges: a full row, then one whose tail, last word included,
    // is dropped.
    random_row(MAX_NODES_DEF);
    random_row(MAX_NODES_DEF + 2);

    random_phase(WORDS_PER_PHASE);
    drain_selections();

    tx_idle_pct = 85;
    rx_idle_pct = 11;
    random_phase(WORDS_PER_PHASE);
    drain_selections();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(WORDS_PER_PHASE);
    drain_selections();

    // Give a stray result time to show up after the last expected one.
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d rows in %0d words; %0d selections checked", rows_sent,
             words_sent, selections_seen);
    $display("%0d fell back to the default node, %0d reported dropped words",
             defaults_seen, overflows_seen);
    if (pending != 0)
      $error("%0d selections never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
